// ===== src/scmus_pkg.sv =====
package scmus_pkg;

  localparam int CLS_W   = 7;
  localparam int SIZE_W  = 32;
  localparam int CNT_W   = 32;
  localparam int BYTES_W = 48;
  localparam int AVG_W   = 48;
  localparam int FRAC_W  = 16;

  localparam logic [1:0] CMD_MAP    = 2'd0;
  localparam logic [1:0] CMD_RECORD = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] MULT_SMALL  = 3'd1;
  localparam logic [2:0] MULT_MEDIUM = 3'd2;
  localparam logic [2:0] MULT_LARGE  = 3'd4;

  localparam longint SMALL_FIRST = 64;
  localparam int     SMALL_CAP   = 64;
  localparam longint MED_FIRST   = 64 * 1024;
  localparam longint MED_STEP0   = 16 * 1024;
  localparam longint MED_LAST    = 1024 * 1024;
  localparam int     MED_CAP     = 96;
  localparam longint LARGE_FIRST = 2 * 1024 * 1024;
  localparam longint LARGE_STEP  = 1024 * 1024;
  localparam longint WORD_MASK   = 64'hFFFF_FFFF;

  localparam logic [12:0] ALPHA_Q16     = 13'd6554;
  localparam logic [15:0] ONE_M_ALPHA_Q16 = 16'd58982;

  typedef struct packed {
    logic [SIZE_W-1:0] max_val;
    logic [2:0]        mult;
  } class_ent_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] bytes;
    logic [AVG_W-1:0]   avg;
  } stats_t;

  typedef struct packed {
    logic adv;
    logic upd;
  } stats_ctl_t;

  function automatic class_ent_t class_ent_f(input int idx, input int n, input int lim);
    class_ent_t ent;
    longint     cur;
    longint     step;
    int         i;
    ent.max_val = '0;
    ent.mult    = MULT_SMALL;
    cur         = SMALL_FIRST;
    i           = 0;
    while (i < SMALL_CAP && i < n && cur <= longint'(lim)) begin
      if (i == idx) begin
        ent.max_val = SIZE_W'(cur);
        ent.mult    = MULT_SMALL;
      end
      cur = cur + (cur >>> 2);
      i++;
    end
    cur  = MED_FIRST;
    step = MED_STEP0;
    while (i < MED_CAP && i < n && cur <= MED_LAST) begin
      if (i == idx) begin
        ent.max_val = SIZE_W'(cur);
        ent.mult    = MULT_MEDIUM;
      end
      cur  = cur + step;
      step = step <<< 1;
      i++;
    end
    cur = LARGE_FIRST;
    while (i < n) begin
      if (i == idx) begin
        ent.max_val = SIZE_W'(cur);
        ent.mult    = MULT_LARGE;
      end
      cur = (cur + LARGE_STEP) & WORD_MASK;
      i++;
    end
    if (idx == n - 1) begin
      ent.max_val = '1;
    end
    return ent;
  endfunction

endpackage

// ===== src/scmus_if.sv =====
interface scmus_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] size;
  logic [6:0]  cls_id;

  modport source (output valid, output cmd, output size, output cls_id, input ready);
  modport sink   (input valid, input cmd, input size, input cls_id, output ready);
endinterface

interface scmus_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [6:0]  class_index;
  logic [31:0] class_min;
  logic [31:0] class_max;
  logic [2:0]  page_mult;
  logic        is_small;
  logic [31:0] alloc_count;
  logic [47:0] total_bytes;
  logic [47:0] avg_size;

  modport source (
    output valid, output valid_res, output class_index, output class_min,
    output class_max, output page_mult, output is_small, output alloc_count,
    output total_bytes, output avg_size, input ready
  );
  modport sink (
    input valid, input valid_res, input class_index, input class_min,
    input class_max, input page_mult, input is_small, input alloc_count,
    input total_bytes, input avg_size, output ready
  );
endinterface

// ===== src/scmus_lookup.sv =====
module scmus_lookup
  import scmus_pkg::*;
#(
  parameter int NUM_CLASSES = 64,
  parameter int SMALL_LIMIT = 65536
) (
  input  logic [SIZE_W-1:0] size,
  output logic [CLS_W-1:0]  cls
);

  logic [NUM_CLASSES-1:0] hit;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cmp
    localparam class_ent_t ENT = class_ent_f(g, NUM_CLASSES, SMALL_LIMIT);
    assign hit[g] = (size <= ENT.max_val);
  end

  always_comb begin
    cls = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        cls = CLS_W'(i);
      end
    end
  end

endmodule

// ===== src/scmus_stats.sv =====
module scmus_stats
  import scmus_pkg::*;
#(
  parameter int NUM_CLASSES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stats_ctl_t                        ctl,
  input  logic [$clog2(NUM_CLASSES)-1:0]    rd_addr,
  input  logic [SIZE_W-1:0]                 upd_size,
  output stats_t                            cur
);

  localparam int CW = $clog2(NUM_CLASSES);

  stats_t                 mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_r;
  stats_t                 rd_data_r;
  stats_t                 fwd_data_r;
  logic                   rd_vld_r;
  logic                   fwd_r;
  logic [CW-1:0]          addr_r;

  stats_t                 old_s;
  stats_t                 new_s;
  logic [63:0]            avg_prod;
  logic [44:0]            size_prod;
  logic [AVG_W:0]         avg_sum;
  logic [BYTES_W:0]       bytes_sum;

  always_comb begin
    old_s     = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : '0);
    avg_prod  = 64'(old_s.avg) * 64'(ONE_M_ALPHA_Q16);
    size_prod = 45'(upd_size) * 45'(ALPHA_Q16);
    avg_sum   = (AVG_W+1)'(size_prod) + (AVG_W+1)'(avg_prod[63:FRAC_W]);
    bytes_sum = (BYTES_W+1)'(old_s.bytes) + (BYTES_W+1)'(upd_size);

    new_s.avg   = (old_s.count == '0) ? {upd_size, FRAC_W'(0)} : avg_sum[AVG_W-1:0];
    new_s.count = (&old_s.count) ? old_s.count : old_s.count + CNT_W'(1);
    new_s.bytes = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];

    cur = ctl.upd ? new_s : old_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (ctl.adv) begin
      rd_vld_r <= vld_r[rd_addr];
      fwd_r    <= ctl.upd && (addr_r == rd_addr);
      if (ctl.upd) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rd_data_r  <= mem[rd_addr];
      fwd_data_r <= new_s;
      addr_r     <= rd_addr;
      if (ctl.upd) begin
        mem[addr_r] <= new_s;
      end
    end
  end

endmodule

// ===== src/size_class_map_with_usage_stats_unit.sv =====
// A result passes through the s1, s2 and output registers after its transaction is accepted.
// Throughput: one transaction per cycle unless the output stalls; the statistics memory does
//   read-modify-write with forwarding of the write in flight, so back-to-back records on one class do not stall.
// Reset (rst_n low, synchronous): empties the pipeline and clears the per-class valid bits;
//   statistics of a class read as zero until its first record. No clearing pass is needed.
module size_class_map_with_usage_stats_unit
  import scmus_pkg::*;
#(
  parameter int NUM_CLASSES = 64,
  parameter int SMALL_LIMIT = 65536
) (
  input logic          clk,
  input logic          rst_n,
  scmus_in_if.sink     in_chan,
  scmus_out_if.source  out_chan
);

  localparam int               CW          = $clog2(NUM_CLASSES);
  localparam logic [CLS_W:0]   NUM_CLS_EXT = (CLS_W+1)'(NUM_CLASSES);

  logic [SIZE_W-1:0] tab_max   [NUM_CLASSES];
  logic [SIZE_W-1:0] tab_min   [NUM_CLASSES];
  logic [2:0]        tab_mult  [NUM_CLASSES];
  logic              tab_small [NUM_CLASSES];

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_tab
    localparam class_ent_t ENT  = class_ent_f(g, NUM_CLASSES, SMALL_LIMIT);
    localparam class_ent_t PREV = class_ent_f(g - 1, NUM_CLASSES, SMALL_LIMIT);
    assign tab_max[g]   = ENT.max_val;
    assign tab_min[g]   = PREV.max_val + SIZE_W'(1);
    assign tab_mult[g]  = ENT.mult;
    assign tab_small[g] = (ENT.max_val <= SIZE_W'(SMALL_LIMIT));
  end

  logic               adv;
  stats_ctl_t         ctl;
  stats_t             cur;

  logic               s1_v_r;
  logic [1:0]         s1_cmd_r;
  logic [SIZE_W-1:0]  s1_size_r;
  logic [CLS_W-1:0]   s1_cid_r;
  logic [CLS_W-1:0]   find_cls;
  logic [CLS_W-1:0]   c1;

  logic               s2_v_r;
  logic               s2_ok_r;
  logic [1:0]         s2_cmd_r;
  logic [SIZE_W-1:0]  s2_size_r;
  logic [CLS_W-1:0]   s2_cls_r;
  logic [CW-1:0]      s2_idx;

  logic               out_v_r;
  logic               out_ok_r;
  logic [CLS_W-1:0]   out_cls_r;
  logic [SIZE_W-1:0]  out_min_r;
  logic [SIZE_W-1:0]  out_max_r;
  logic [2:0]         out_mult_r;
  logic               out_small_r;
  stats_t             out_stats_r;

  assign adv           = !out_v_r || out_chan.ready;
  assign in_chan.ready = adv;

  scmus_lookup #(
    .NUM_CLASSES (NUM_CLASSES),
    .SMALL_LIMIT (SMALL_LIMIT)
  ) u_lookup (
    .size (s1_size_r),
    .cls  (find_cls)
  );

  assign c1      = (s1_cmd_r == CMD_MAP) ? find_cls : s1_cid_r;
  assign s2_idx  = s2_cls_r[CW-1:0];
  assign ctl.adv = adv;
  assign ctl.upd = s2_v_r && s2_ok_r && (s2_cmd_r == CMD_RECORD);

  scmus_stats #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_stats (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (c1[CW-1:0]),
    .upd_size (s2_size_r),
    .cur      (cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_chan.valid;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= in_chan.cmd;
      s1_size_r <= in_chan.size;
      s1_cid_r  <= in_chan.cls_id;

      s2_cmd_r  <= s1_cmd_r;
      s2_size_r <= s1_size_r;
      s2_cls_r  <= c1;
      s2_ok_r   <= ({1'b0, c1} < NUM_CLS_EXT);

      out_ok_r  <= s2_ok_r;
      out_cls_r <= s2_cls_r;
      if (s2_ok_r) begin
        out_min_r   <= tab_min[s2_idx];
        out_max_r   <= tab_max[s2_idx];
        out_mult_r  <= tab_mult[s2_idx];
        out_small_r <= tab_small[s2_idx];
        out_stats_r <= cur;
      end else begin
        out_min_r   <= '0;
        out_max_r   <= '0;
        out_mult_r  <= MULT_SMALL;
        out_small_r <= 1'b0;
        out_stats_r <= '0;
      end
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.valid_res   = out_ok_r;
  assign out_chan.class_index = out_cls_r;
  assign out_chan.class_min   = out_min_r;
  assign out_chan.class_max   = out_max_r;
  assign out_chan.page_mult   = out_mult_r;
  assign out_chan.is_small    = out_small_r;
  assign out_chan.alloc_count = out_stats_r.count;
  assign out_chan.total_bytes = out_stats_r.bytes;
  assign out_chan.avg_size    = out_stats_r.avg;

  a_map_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && (s2_cmd_r == CMD_MAP) |-> s2_ok_r)
    else $error("size lookup produced an out-of-range class");

  a_record_counts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl.upd |=> out_v_r && (out_stats_r.count != '0))
    else $error("recorded transaction returned a zero allocation count");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_ok_r |-> out_min_r <= out_max_r)
    else $error("class minimum above class maximum");

  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ok_r |-> (out_stats_r == '0) && (out_mult_r == MULT_SMALL))
    else $error("invalid class carries statistics");

endmodule
